// ===== sv/tgr_pkg.sv =====
package tgr_pkg;

   // Glyph geometry and store size
   localparam int GLYPH_HEIGHT = 6;
   localparam int GLYPH_WIDTH  = 8;
   localparam int GLYPH_COUNT  = 128;
   localparam int STORE_DEPTH  = 768;
   localparam int STORE_AW     = $clog2(STORE_DEPTH);

   // Field widths
   localparam int ACTION_W = 2;
   localparam int SLOT_W   = 10;
   localparam int BITS_W   = 8;
   localparam int COORD_W  = 11;
   localparam int CODE_W   = 8;
   localparam int PADDR_W  = 20;
   localparam int COLOUR_W = 8;
   localparam int DIM_W    = 11;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   // Internal widths
   localparam int ROW_W   = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
   localparam int COL_W   = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;
   localparam int BSEL_W  = $clog2(BITS_W);
   localparam int BASE_W  = CODE_W + 5;
   localparam int POS_W   = COORD_W + 1;

   localparam logic [CODE_W-1:0] NEWLINE_CODE = CODE_W'(10);

   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(320);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(200);

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD   = 2'd0,
      ACT_ORIGIN = 2'd1,
      ACT_DRAW   = 2'd2
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEXT_COLOUR = 2'd0,
      CSR_BACK_COLOUR = 2'd1,
      CSR_SCR_WIDTH   = 2'd2,
      CSR_SCR_HEIGHT  = 2'd3
   } csr_index_type;

endpackage

// ===== sv/tgr_if.sv =====
interface tgr_req_if;
   import tgr_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [ACTION_W-1:0]        action;
   logic [SLOT_W-1:0]          glyph_slot;
   logic [BITS_W-1:0]          glyph_bits;
   logic signed [COORD_W-1:0]  origin_x;
   logic signed [COORD_W-1:0]  origin_y;
   logic [CODE_W-1:0]          char_code;

   modport source (output valid, action, glyph_slot, glyph_bits, origin_x, origin_y,
                   char_code, input ready);
   modport sink   (input valid, action, glyph_slot, glyph_bits, origin_x, origin_y,
                   char_code, output ready);
endinterface

interface tgr_rsp_if;
   import tgr_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [PADDR_W-1:0]   pixel_address;
   logic [COLOUR_W-1:0]  pixel_value;
   logic                 last;

   modport source (output valid, pixel_address, pixel_value, last, input ready);
   modport sink   (input valid, pixel_address, pixel_value, last, output ready);
endinterface

// ===== sv/tgr_ram.sv =====
module tgr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/text_glyph_renderer_top.sv =====
// Bitmap-font text renderer. Load beats write one glyph row byte into a 768 x 8 glyph
// RAM, origin beats set the pen and line start, and draw beats take a newline (code
// 10), only advance the pen for codes at or past GLYPH_COUNT, or scan the glyph row
// by row, MSB first, giving one framebuffer write per on-screen pixel with last set
// on the final one. Load, origin, newline and out-of-range codes leave the block idle,
// ready for the next beat. A drawn character first reads its top glyph row from the
// RAM and then scans one pixel position per cycle, off-screen positions included,
// while the result side is not stalled; the next row is read during the last column
// of the current one. No new beat is taken while a glyph is scanned.
module text_glyph_renderer_top
   import tgr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   tgr_req_if.sink                 req_bus,
   tgr_rsp_if.source               rsp_bus,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wr_data
);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type             state_ff, state_in;
   logic [COORD_W-1:0]    pen_x_ff, pen_x_in;
   logic [COORD_W-1:0]    pen_y_ff, pen_y_in;
   logic [COORD_W-1:0]    line_x_ff, line_x_in;
   logic [COLOUR_W-1:0]   text_col_ff, back_col_ff;
   logic [DIM_W-1:0]      scr_w_ff, scr_h_ff;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [BASE_W-1:0]     addr_ff, addr_in;
   logic                  oob_ff, oob_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PADDR_W-1:0]    paddr_ff, paddr_in;
   logic [COLOUR_W-1:0]   pval_ff, pval_in;
   logic                  last_ff, last_in;

   logic                  accept;
   logic [BASE_W-1:0]     base_addr;
   logic                  rd_en;
   logic [BASE_W-1:0]     rd_addr;
   logic [BITS_W-1:0]     rd_data;
   logic [BITS_W-1:0]     row_bits;
   logic                  advance;
   logic [POS_W-1:0]      px, py;
   logic                  col_vis, row_vis, col_end, row_end;
   logic [BSEL_W-1:0]     bit_sel;
   logic [2*DIM_W-1:0]    row_base;
   logic                  col_done, row_done;

   assign accept      = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign base_addr   = BASE_W'(req_bus.char_code) * BASE_W'(GLYPH_HEIGHT);

   tgr_ram #(
      .WIDTH (BITS_W),
      .DEPTH (STORE_DEPTH)
   ) u_glyph_ram (
      .clock   (clock),
      .wr_en   (accept && req_bus.action == ACT_LOAD
                && 32'(req_bus.glyph_slot) < STORE_DEPTH),
      .wr_addr (STORE_AW'(req_bus.glyph_slot)),
      .wr_data (req_bus.glyph_bits),
      .rd_en   (rd_en),
      .rd_addr (STORE_AW'(rd_addr)),
      .rd_data (rd_data)
   );

   // Pixel position and clipping for the current scan point
   assign row_bits = oob_ff ? '0 : rd_data;
   assign advance  = !rsp_valid_ff || rsp_bus.ready;
   assign px       = {pen_x_ff[COORD_W-1], pen_x_ff} + POS_W'(col_ff);
   assign py       = {pen_y_ff[COORD_W-1], pen_y_ff} + POS_W'(row_ff);
   assign col_vis  = !px[POS_W-1] && (px[COORD_W-1:0] < scr_w_ff);
   assign row_vis  = !py[POS_W-1] && (py[COORD_W-1:0] < scr_h_ff);
   assign col_done = (col_ff == COL_W'(GLYPH_WIDTH - 1));
   assign row_done = (row_ff == ROW_W'(GLYPH_HEIGHT - 1));
   assign col_end  = col_done || ({1'b0, px[COORD_W-1:0]} + POS_W'(1) >= {1'b0, scr_w_ff});
   assign row_end  = row_done || ({1'b0, py[COORD_W-1:0]} + POS_W'(1) >= {1'b0, scr_h_ff});
   assign bit_sel  = BSEL_W'(BITS_W - 1) - BSEL_W'(col_ff);
   assign row_base = py[COORD_W-1:0] * scr_w_ff;

   always_comb begin
      state_in     = state_ff;
      pen_x_in     = pen_x_ff;
      pen_y_in     = pen_y_ff;
      line_x_in    = line_x_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      addr_in      = addr_ff;
      oob_in       = oob_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      paddr_in     = paddr_ff;
      pval_in      = pval_ff;
      last_in      = last_ff;
      rd_en        = 1'b0;
      rd_addr      = addr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_bus.action)
                  ACT_ORIGIN: begin
                     pen_x_in  = req_bus.origin_x;
                     line_x_in = req_bus.origin_x;
                     pen_y_in  = req_bus.origin_y;
                  end
                  ACT_DRAW: begin
                     priority if (req_bus.char_code == NEWLINE_CODE) begin
                        pen_x_in = line_x_ff;
                        pen_y_in = pen_y_ff + COORD_W'(GLYPH_HEIGHT);
                     end else if (32'(req_bus.char_code) < GLYPH_COUNT) begin
                        rd_en    = 1'b1;
                        rd_addr  = base_addr;
                        addr_in  = base_addr;
                        oob_in   = 32'(base_addr) >= STORE_DEPTH;
                        row_in   = '0;
                        col_in   = '0;
                        state_in = ST_SCAN;
                     end else begin
                        pen_x_in = pen_x_ff + COORD_W'(GLYPH_WIDTH);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (advance) begin
               if (col_vis && row_vis) begin
                  rsp_valid_in = 1'b1;
                  paddr_in     = PADDR_W'(row_base) + PADDR_W'(px[COORD_W-1:0]);
                  pval_in      = row_bits[bit_sel] ? text_col_ff : back_col_ff;
                  last_in      = col_end && row_end;
               end
               if (col_done) begin
                  col_in = '0;
                  if (row_done) begin
                     pen_x_in = pen_x_ff + COORD_W'(GLYPH_WIDTH);
                     state_in = ST_IDLE;
                  end else begin
                     // fetch the next row so it lands with its first column
                     row_in  = row_ff + ROW_W'(1);
                     addr_in = addr_ff + BASE_W'(1);
                     rd_en   = 1'b1;
                     rd_addr = addr_ff + BASE_W'(1);
                     oob_in  = 32'(addr_ff + BASE_W'(1)) >= STORE_DEPTH;
                  end
               end else begin
                  col_in = col_ff + COL_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
         line_x_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         text_col_ff  <= '0;
         back_col_ff  <= '0;
         scr_w_ff     <= WIDTH_RESET;
         scr_h_ff     <= HEIGHT_RESET;
      end else begin
         state_ff     <= state_in;
         pen_x_ff     <= pen_x_in;
         pen_y_ff     <= pen_y_in;
         line_x_ff    <= line_x_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index_type'(csr_index))
               CSR_TEXT_COLOUR: text_col_ff <= COLOUR_W'(csr_wr_data);
               CSR_BACK_COLOUR: back_col_ff <= COLOUR_W'(csr_wr_data);
               CSR_SCR_WIDTH:   scr_w_ff    <= DIM_W'(csr_wr_data);
               CSR_SCR_HEIGHT:  scr_h_ff    <= DIM_W'(csr_wr_data);
               default: begin
               end
            endcase
         end
      end
      row_ff   <= row_in;
      col_ff   <= col_in;
      addr_ff  <= addr_in;
      oob_ff   <= oob_in;
      paddr_ff <= paddr_in;
      pval_ff  <= pval_in;
      last_ff  <= last_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.pixel_address = paddr_ff;
   assign rsp_bus.pixel_value   = pval_ff;
   assign rsp_bus.last          = last_ff;

endmodule

// ===== sv/tgr_checker.sv =====
module tgr_checker
   import tgr_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic [ACTION_W-1:0]  req_action,
   input logic [CODE_W-1:0]    req_char_code,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [PADDR_W-1:0]   rsp_pixel_address,
   input logic [COLOUR_W-1:0]  rsp_pixel_value,
   input logic                 rsp_last
);

   logic req_beat;
   logic glyph_draw;

   assign req_beat   = req_valid && req_ready;
   assign glyph_draw = req_action == ACT_DRAW && req_char_code != NEWLINE_CODE
                       && 32'(req_char_code) < GLYPH_COUNT;

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_address)
         && $stable(rsp_pixel_value) && $stable(rsp_last))
      else $error("stalled result beat changed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   a_short_items: assert property (@(posedge clock) disable iff (reset)
      req_beat && !glyph_draw |=> req_ready)
      else $error("single-cycle item blocked the input");

   a_glyph_busy: assert property (@(posedge clock) disable iff (reset)
      req_beat && glyph_draw |=> !req_ready)
      else $error("input taken during glyph scan");

endmodule

bind text_glyph_renderer_top tgr_checker u_tgr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .req_action        (req_bus.action),
   .req_char_code     (req_bus.char_code),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_pixel_address (rsp_bus.pixel_address),
   .rsp_pixel_value   (rsp_bus.pixel_value),
   .rsp_last          (rsp_bus.last)
);

// ===== tb/sv/text_glyph_renderer_top_test.sv =====
module text_glyph_renderer_top_test;
   import tgr_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam int GLYPH_PIXELS  = GLYPH_HEIGHT * GLYPH_WIDTH;
   localparam int SETTLE_CYCLES = 2 * (GLYPH_PIXELS + 1);
   localparam int HOLD_AFTER    = 600;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASE_ITEMS   = 62;
   localparam int COORD_MAX     = 1023;

   typedef struct {
      logic [ACTION_W-1:0]       action;
      logic [SLOT_W-1:0]         slot;
      logic [BITS_W-1:0]         bits;
      logic signed [COORD_W-1:0] ox;
      logic signed [COORD_W-1:0] oy;
      logic [CODE_W-1:0]         code;
   } glyph_cmd_type;

   typedef struct {
      logic [PADDR_W-1:0]  addr;
      logic [COLOUR_W-1:0] value;
      logic                last;
   } pixel_write_type;

   typedef enum {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_THIRD} rx_pace_type;

   // Text renderer predictor plus the queue of framebuffer writes still owed.
   class glyph_scoreboard;
      logic [BITS_W-1:0]         font_rows [STORE_DEPTH];
      bit                        row_written [STORE_DEPTH];
      logic signed [COORD_W-1:0] pen_x;
      logic signed [COORD_W-1:0] pen_y;
      logic signed [COORD_W-1:0] line_x;
      logic [COLOUR_W-1:0]       ink;
      logic [COLOUR_W-1:0]       paper;
      logic [DIM_W-1:0]          scr_w;
      logic [DIM_W-1:0]          scr_h;
      pixel_write_type           pending_writes[$];
      int                        errors;

      function new();
         pen_x  = '0;
         pen_y  = '0;
         line_x = '0;
         ink    = '0;
         paper  = '0;
         scr_w  = WIDTH_RESET;
         scr_h  = HEIGHT_RESET;
         errors = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_TEXT_COLOUR: ink   = data[COLOUR_W-1:0];
            CSR_BACK_COLOUR: paper = data[COLOUR_W-1:0];
            CSR_SCR_WIDTH:   scr_w = data[DIM_W-1:0];
            CSR_SCR_HEIGHT:  scr_h = data[DIM_W-1:0];
            default: ;
         endcase
      endfunction

      function bit glyph_complete(int code);
         for (int r = 0; r < GLYPH_HEIGHT; r++)
            if (!row_written[code * GLYPH_HEIGHT + r]) return 1'b0;
         return 1'b1;
      endfunction

      // Any fully loaded glyph other than newline, or -1 if none yet.
      function int pick_glyph();
         int start;
         int c;
         start = $urandom_range(0, GLYPH_COUNT - 1);
         for (int k = 0; k < GLYPH_COUNT; k++) begin
            c = (start + k) % GLYPH_COUNT;
            if (c != NEWLINE_CODE && glyph_complete(c)) return c;
         end
         return -1;
      endfunction

      function void note_request(glyph_cmd_type cmd);
         int x0, y0, px, py, sw, sh, slot, emitted;
         logic [BITS_W-1:0] row;
         logic [31:0] lin;
         pixel_write_type pw;
         case (cmd.action)
            ACT_LOAD: begin
               if (cmd.slot < STORE_DEPTH) begin
                  font_rows[cmd.slot]   = cmd.bits;
                  row_written[cmd.slot] = 1'b1;
               end
            end
            ACT_ORIGIN: begin
               pen_x  = cmd.ox;
               line_x = cmd.ox;
               pen_y  = cmd.oy;
            end
            ACT_DRAW: begin
               x0 = pen_x;
               y0 = pen_y;
               sw = scr_w;
               sh = scr_h;
               if (cmd.code == NEWLINE_CODE) begin
                  pen_x = line_x;
                  pen_y = COORD_W'(y0 + GLYPH_HEIGHT);
               end else begin
                  if (cmd.code < GLYPH_COUNT) begin
                     emitted = 0;
                     for (int i = 0; i < GLYPH_HEIGHT; i++) begin
                        slot = cmd.code * GLYPH_HEIGHT + i;
                        row  = (slot < STORE_DEPTH) ? font_rows[slot] : '0;
                        py   = y0 + i;
                        if (py < 0 || py >= sh) continue;
                        for (int j = 0; j < GLYPH_WIDTH; j++) begin
                           px = x0 + j;
                           if (px < 0 || px >= sw) continue;
                           lin      = py * sw + px;
                           pw.addr  = lin[PADDR_W-1:0];
                           pw.value = row[BITS_W-1-j] ? ink : paper;
                           pw.last  = 1'b0;
                           pending_writes.push_back(pw);
                           emitted++;
                        end
                     end
                     if (emitted > 0) pending_writes[pending_writes.size()-1].last = 1'b1;
                  end
                  // pen advances even for codes with no glyph
                  pen_x = COORD_W'(x0 + GLYPH_WIDTH);
               end
            end
            default: ;
         endcase
      endfunction

      function void check_pixel(logic [PADDR_W-1:0] addr, logic [COLOUR_W-1:0] value,
                                logic last);
         pixel_write_type want;
         if (pending_writes.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected pixel write: addr %h value %h last %b", addr, value, last);
            return;
         end
         want = pending_writes.pop_front();
         if (addr !== want.addr || value !== want.value || last !== want.last) begin
            errors++;
            if (errors <= 10)
               $display("pixel write differs: expected addr %h value %h last %b, got %h %h %b",
                        want.addr, want.value, want.last, addr, value, last);
         end
      endfunction

      function int outstanding();
         return pending_writes.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   tgr_req_if req_bus();
   tgr_rsp_if rsp_bus();

   text_glyph_renderer_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   glyph_scoreboard sb = new();

   int          burst_left   = 0;
   int          pixels_taken = 0;
   bit          hold_done    = 1'b0;
   int          hold_left    = 0;
   int          pace_left    = 0;
   rx_pace_type rx_pace      = RX_ALWAYS;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   initial begin
      #10_000_000;
      $display("text_glyph_renderer_top: mismatch");
      $finish;
   end

   // Collect pixel writes and pace the result side.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         sb.check_pixel(rsp_bus.pixel_address, rsp_bus.pixel_value, rsp_bus.last);
         pixels_taken++;
      end
      if (!hold_done && pixels_taken >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (pace_left == 0) begin
         rx_pace   = rx_pace_type'($urandom_range(0, 3));
         pace_left = $urandom_range(20, 80);
      end else begin
         pace_left--;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         case (rx_pace)
            RX_ALWAYS: rsp_bus.ready <= 1'b1;
            RX_COIN:   rsp_bus.ready <= 1'($urandom_range(0, 1));
            RX_MOSTLY: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            default:   rsp_bus.ready <= (pace_left % 3 == 0);
         endcase
      end
   end

   function automatic glyph_cmd_type scrambled_cmd();
      glyph_cmd_type c;
      c.action = ACT_UNUSED;
      c.slot   = SLOT_W'($urandom);
      c.bits   = BITS_W'($urandom);
      c.ox     = COORD_W'($urandom);
      c.oy     = COORD_W'($urandom);
      c.code   = CODE_W'($urandom);
      return c;
   endfunction

   function automatic glyph_cmd_type load_cmd(int slot, int bits);
      glyph_cmd_type c = scrambled_cmd();
      c.action = ACT_LOAD;
      c.slot   = SLOT_W'(slot);
      c.bits   = BITS_W'(bits);
      return c;
   endfunction

   function automatic glyph_cmd_type origin_cmd(int x, int y);
      glyph_cmd_type c = scrambled_cmd();
      c.action = ACT_ORIGIN;
      c.ox     = COORD_W'(x);
      c.oy     = COORD_W'(y);
      return c;
   endfunction

   function automatic glyph_cmd_type draw_cmd(int code);
      glyph_cmd_type c = scrambled_cmd();
      c.action = ACT_DRAW;
      c.code   = CODE_W'(code);
      return c;
   endfunction

   // Coordinate around the visible span so that clipping happens on both sides.
   function automatic int near_coord(int extent);
      int v;
      v = int'($urandom_range(0, extent + 17)) - 12;
      return (v > COORD_MAX) ? COORD_MAX : v;
   endfunction

   task automatic send_cmd(glyph_cmd_type cmd);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid      <= 1'b1;
      req_bus.action     <= cmd.action;
      req_bus.glyph_slot <= cmd.slot;
      req_bus.glyph_bits <= cmd.bits;
      req_bus.origin_x   <= cmd.ox;
      req_bus.origin_y   <= cmd.oy;
      req_bus.char_code  <= cmd.code;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(cmd);
   endtask

   // Hold the sender until every pixel has come back, then let a silent draw finish.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, int data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= CSR_DATA_W'(data);
      @(posedge clock);
      sb.set_register(idx, CSR_DATA_W'(data));
   endtask

   task automatic program_screen(int ink, int paper, int w, int h);
      write_reg(CSR_TEXT_COLOUR, ink);
      write_reg(CSR_BACK_COLOUR, paper);
      write_reg(CSR_SCR_WIDTH, w);
      write_reg(CSR_SCR_HEIGHT, h);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_phase(int target);
      int done_items;
      int roll;
      int code;
      int slot;
      done_items = 0;
      while (done_items < target) begin
         roll = $urandom_range(0, 99);
         code = sb.pick_glyph();
         if (roll < 12 || (roll >= 42 && code < 0)) begin
            // whole glyph, top row first
            code = $urandom_range(0, GLYPH_COUNT - 1);
            for (int r = 0; r < GLYPH_HEIGHT; r++)
               send_cmd(load_cmd(code * GLYPH_HEIGHT + r, $urandom_range(0, 255)));
            done_items += GLYPH_HEIGHT;
         end else if (roll < 16) begin
            slot = $urandom_range(0, (1 << SLOT_W) - 1);
            send_cmd(load_cmd(slot, $urandom_range(0, 255)));
            if (slot < STORE_DEPTH) done_items++;
         end else if (roll < 30) begin
            if ($urandom_range(0, 4) == 0)
               send_cmd(origin_cmd($urandom, $urandom));
            else
               send_cmd(origin_cmd(near_coord(sb.scr_w), near_coord(sb.scr_h)));
            done_items++;
         end else if (roll < 36) begin
            send_cmd(draw_cmd(NEWLINE_CODE));
            done_items++;
         end else if (roll < 40) begin
            send_cmd(draw_cmd($urandom_range(GLYPH_COUNT, 255)));
            done_items++;
         end else if (roll < 42) begin
            send_cmd(scrambled_cmd());
         end else begin
            send_cmd(draw_cmd(code));
            done_items++;
         end
      end
      settle();
   endtask

   initial begin
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = '0;
      csr_wr_data        = '0;
      req_bus.valid      = 1'b0;
      req_bus.action     = '0;
      req_bus.glyph_slot = '0;
      req_bus.glyph_bits = '0;
      req_bus.origin_x   = '0;
      req_bus.origin_y   = '0;
      req_bus.char_code  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Colours only; screen size stays at its reset value.
      write_reg(CSR_TEXT_COLOUR, 255);
      write_reg(CSR_BACK_COLOUR, 0);
      csr_wr_en <= 1'b0;

      send_cmd(load_cmd(0, 8'h80));
      send_cmd(load_cmd(1, 8'h01));
      send_cmd(load_cmd(2, 8'hFF));
      send_cmd(load_cmd(3, 8'h00));
      send_cmd(load_cmd(4, 8'hA5));
      send_cmd(load_cmd(5, 8'h5A));
      send_cmd(load_cmd(762, 8'hC3));
      send_cmd(load_cmd(763, 8'h3C));
      send_cmd(load_cmd(764, 8'h81));
      send_cmd(load_cmd(765, 8'h7E));
      send_cmd(load_cmd(766, 8'h0F));
      send_cmd(load_cmd(STORE_DEPTH - 1, 8'hF0));
      // slot past the store: dropped
      send_cmd(load_cmd((1 << SLOT_W) - 1, 8'hFF));
      send_cmd(scrambled_cmd());
      send_cmd(origin_cmd(0, 0));
      send_cmd(draw_cmd(0));
      send_cmd(draw_cmd(GLYPH_COUNT - 1));
      send_cmd(draw_cmd(NEWLINE_CODE));
      // clipped on the left and top, then on the right and bottom
      send_cmd(origin_cmd(-4, -3));
      send_cmd(draw_cmd(0));
      send_cmd(origin_cmd(316, 197));
      send_cmd(draw_cmd(GLYPH_COUNT - 1));
      send_cmd(origin_cmd(-1024, -1024));
      send_cmd(draw_cmd(0));
      // past the glyph count: no pixels, pen wraps around
      send_cmd(origin_cmd(1020, 1023));
      send_cmd(draw_cmd(255));
      send_cmd(draw_cmd(0));
      send_cmd(draw_cmd(NEWLINE_CODE));
      settle();

      program_screen(0, 255, 1024, 1024);
      random_phase(PHASE_ITEMS);
      program_screen($urandom_range(0, 255), $urandom_range(0, 255), 1, 1);
      random_phase(PHASE_ITEMS);
      program_screen($urandom_range(0, 255), $urandom_range(0, 255), 1024, 1);
      random_phase(PHASE_ITEMS);
      program_screen($urandom_range(0, 255), $urandom_range(0, 255), 1, 1024);
      random_phase(PHASE_ITEMS);
      program_screen($urandom_range(0, 255), $urandom_range(0, 255), 13, 9);
      random_phase(PHASE_ITEMS);
      program_screen(255, $urandom_range(0, 255), $urandom_range(1, 1024),
                     $urandom_range(1, 1024));
      random_phase(PHASE_ITEMS);

      if (sb.errors == 0 && sb.outstanding() == 0)
         $display("text_glyph_renderer_top: match");
      else
         $display("text_glyph_renderer_top: mismatch");
      $finish;
   end

endmodule
